FILE: src/keymap_layer_resolver_macros.svh
// Assertion macros used by the keymap layer resolver back end.
`ifndef KEYMAP_LAYER_RESOLVER_MACROS_SVH
`define KEYMAP_LAYER_RESOLVER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property with reset masking.
`define KLR_ASSERT(lbl, clock, resetn, prop) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("keymap layer resolver assertion failed");
// Checked property that also holds while reset is asserted.
`define KLR_ASSERT_ALWAYS(lbl, clock, prop) \
    lbl: assert property (@(posedge clock) prop) \
        else $error("keymap layer resolver assertion failed");
`else
`define KLR_ASSERT(lbl, clock, resetn, prop)
`define KLR_ASSERT_ALWAYS(lbl, clock, prop)
`endif

`endif

FILE: src/kmlr_pkg.sv
// Types, constants and helper functions of the keymap layer resolver.
`default_nettype none

package kmlr_pkg;

    localparam int NUM_LAYERS   = 16;
    localparam int NUM_KEYS     = 64;
    localparam int NUM_PROFILES = 4;
    localparam int STORE_DEPTH  = NUM_PROFILES * NUM_LAYERS * NUM_KEYS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int MODE_W  = 3;
    localparam int LAYER_W = 4;
    localparam int KEY_W   = 6;
    localparam int PROF_W  = 2;
    localparam int CODE_W  = 16;
    localparam int MASK_W  = 16;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 2;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [LAYER_W-1:0] layer_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [PROF_W-1:0]  prof_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Input operations.
    localparam mode_t MODE_ON      = 3'd0;
    localparam mode_t MODE_OFF     = 3'd1;
    localparam mode_t MODE_TOGGLE  = 3'd2;
    localparam mode_t MODE_GOTO    = 3'd3;
    localparam mode_t MODE_DEFAULT = 3'd4;
    localparam mode_t MODE_WRITE   = 3'd5;
    localparam mode_t MODE_LOOKUP  = 3'd6;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_PROFILE     = 2'd0;
    localparam cfg_idx_t CFG_TRANSPARENT = 2'd1;

    // Work kinds handed from the front end to the back end.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_WRITE  = 2'd1;
    localparam kind_t KIND_LOOKUP = 2'd2;

    typedef struct packed {
        kind_t  kind;
        mask_t  mask;
        layer_t base;
        layer_t layer;
        key_t   key;
        prof_t  prof;
        code_t  code;
        layer_t cur;
    } work_t;

    // Highest set bit of a layer mask; zero for an empty mask.
    function automatic layer_t top_bit(mask_t m);
        layer_t r;
        r = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (m[i])
            begin
                r = layer_t'(i);
            end
        end
        return r;
    endfunction

    // Keymap store address of one profile, layer and key.
    function automatic addr_t slot(prof_t p, layer_t l, key_t k);
        addr_t a;
        a = addr_t'(p) * addr_t'(NUM_LAYERS) + addr_t'(l);
        a = a * addr_t'(NUM_KEYS) + addr_t'(k);
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: src/keymap_layer_resolver.sv
// Top level of the keymap layer resolver: layer stack with keymap lookup.
//
//  Channel   Direction  Handshake                        Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    s_axis_tdata (32 bits)
//  m_axis    out        m_axis_tvalid / m_axis_tready    m_axis_tdata (24 bits)
//  cfg       in         cfg_we (no wait, no read-back)   cfg_index, cfg_data
//
// A non-lookup item occupies the back end while S_IDLE takes it from the
// queue and S_OUT loads the output register, which waits on a stalled output.
// A lookup passes through S_WALK between them and reads the active layers
// from the top, one word per cycle through the single RAM port, until a
// non-transparent keycode is found (up to 16, then the default entry, taken in S_BASE).
// The front end updates the layer mask as soon as an item is transferred and
// queues the work, so it keeps taking items while the back end is busy, up to
// the two-entry queue. Reset clears the layer mask, the default layer and all
// handshake state and sets the configuration registers to profile 0 and
// transparent code 1; keymap RAM entries hold their old contents until written.
`default_nettype none

module keymap_layer_resolver (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_axis_tdata fields from bit 0: mode[2:0], layer[6:3], key_index[12:7],
    // entry_profile[14:13], entry_code[30:15], zero[31].
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [kmlr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // m_axis_tdata fields from bit 0: current_layer[3:0], resolved_code[19:4],
    // zero[23:20].
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [kmlr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // Register 0 is active_profile, register 1 is transparent_code.
    input  wire logic                             cfg_we,
    input  wire kmlr_pkg::cfg_idx_t               cfg_index,
    input  wire logic [kmlr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Classified work travels from the front end to the back end as one struct.
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    kmlr_pkg::work_t q_in;
    kmlr_pkg::work_t q_head;

    kmlr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (q_push),
        .push_data (q_in)
    );

    kmlr_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end owns the configuration registers, the keymap RAM and the
    // output register, so a finished result can wait there while the next
    // queued item is already being worked on.
    kmlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: src/kmlr_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module kmlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: src/kmlr_fifo.sv
// Short queue of classified work between the front end and the back end.
`default_nettype none

module kmlr_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire kmlr_pkg::work_t push_data,
    input  wire logic           pop,
    output kmlr_pkg::work_t     head,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = $clog2(kmlr_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(kmlr_pkg::FIFO_DEPTH + 1);

    kmlr_pkg::work_t slots_reg [kmlr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(kmlr_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(kmlr_pkg::FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = advance(wr_ptr_reg);
        end
        if (pop)
        begin
            rd_ptr_next = advance(rd_ptr_reg);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/kmlr_front.sv
// Front end: accepts input items, updates the layer state and classifies work.
`default_nettype none

module kmlr_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic [kmlr_pkg::IN_DATA_W-1:0]   in_data,
    input  wire logic                             q_full,
    output logic                                  in_ready,
    output logic                                  push,
    output kmlr_pkg::work_t                       push_data
);

    kmlr_pkg::mode_t  mode;
    kmlr_pkg::layer_t layer;
    kmlr_pkg::key_t   key;
    kmlr_pkg::prof_t  prof;
    kmlr_pkg::code_t  code;

    kmlr_pkg::mask_t  mask_reg, mask_next;
    kmlr_pkg::layer_t base_reg, base_next;
    kmlr_pkg::mask_t  layer_bit;
    logic             lay_ok, key_ok, prof_ok;

    // Input fields, lowest bits first.
    assign mode  = in_data[2:0];
    assign layer = in_data[6:3];
    assign key   = in_data[12:7];
    assign prof  = in_data[14:13];
    assign code  = in_data[30:15];

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign lay_ok    = 32'(layer) < 32'(kmlr_pkg::NUM_LAYERS);
    assign key_ok    = 32'(key) < 32'(kmlr_pkg::NUM_KEYS);
    assign prof_ok   = 32'(prof) < 32'(kmlr_pkg::NUM_PROFILES);
    assign layer_bit = kmlr_pkg::mask_t'(1) << layer;

    always_comb
    begin
        mask_next = mask_reg;
        base_next = base_reg;
        push_data = '0;
        push_data.kind  = kmlr_pkg::KIND_NONE;
        push_data.layer = layer;
        push_data.key   = key;
        push_data.prof  = prof;
        push_data.code  = code;
        case (mode)
            kmlr_pkg::MODE_ON:
            begin
                if (lay_ok)
                begin
                    mask_next = mask_reg | layer_bit;
                end
            end
            kmlr_pkg::MODE_OFF:
            begin
                if (lay_ok)
                begin
                    mask_next = mask_reg & ~layer_bit;
                end
            end
            kmlr_pkg::MODE_TOGGLE:
            begin
                if (lay_ok)
                begin
                    mask_next = mask_reg ^ layer_bit;
                end
            end
            kmlr_pkg::MODE_GOTO:
            begin
                if (lay_ok)
                begin
                    mask_next = layer_bit;
                end
            end
            kmlr_pkg::MODE_DEFAULT:
            begin
                if (lay_ok)
                begin
                    base_next = layer;
                end
            end
            kmlr_pkg::MODE_WRITE:
            begin
                if (lay_ok && key_ok && prof_ok)
                begin
                    push_data.kind = kmlr_pkg::KIND_WRITE;
                end
            end
            kmlr_pkg::MODE_LOOKUP:
            begin
                if (key_ok)
                begin
                    push_data.kind = kmlr_pkg::KIND_LOOKUP;
                end
            end
            default:
            begin
            end
        endcase
        push_data.mask = mask_next;
        push_data.base = base_next;
        push_data.cur  = (mask_next == '0) ? base_next : kmlr_pkg::top_bit(mask_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            base_reg <= '0;
        end
        else if (push)
        begin
            mask_reg <= mask_next;
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/kmlr_back.sv
// Back end: keymap writes, layer walk for lookups and the output register.
`default_nettype none

`include "keymap_layer_resolver_macros.svh"

module kmlr_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire kmlr_pkg::cfg_idx_t                cfg_index,
    input  wire logic [kmlr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire kmlr_pkg::work_t                   head,
    input  wire logic                              q_empty,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [kmlr_pkg::OUT_DATA_W-1:0]        out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_BASE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    kmlr_pkg::prof_t  profile_reg;
    kmlr_pkg::code_t  transp_reg;

    kmlr_pkg::mask_t  walk_mask_reg, walk_mask_next;
    kmlr_pkg::mask_t  work_mask_reg, work_mask_next;
    kmlr_pkg::layer_t base_reg, base_next;
    kmlr_pkg::key_t   key_reg, key_next;
    kmlr_pkg::layer_t cur_reg, cur_next;
    kmlr_pkg::code_t  res_reg, res_next;
    logic             pend_reg, pend_next;

    logic             out_valid_reg, out_valid_next;
    kmlr_pkg::layer_t out_layer_reg, out_layer_next;
    kmlr_pkg::code_t  out_code_reg, out_code_next;

    logic             ram_we;
    kmlr_pkg::addr_t  ram_addr;
    kmlr_pkg::code_t  ram_wdata;
    kmlr_pkg::code_t  ram_rdata;
    kmlr_pkg::layer_t walk_top;

    kmlr_ram #(
        .WIDTH (kmlr_pkg::CODE_W),
        .DEPTH (kmlr_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign walk_top  = kmlr_pkg::top_bit(walk_mask_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0000, out_code_reg, out_layer_reg};

    always_comb
    begin
        state_next     = state_reg;
        walk_mask_next = walk_mask_reg;
        work_mask_next = work_mask_reg;
        base_next      = base_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_layer_next = out_layer_reg;
        out_code_next  = out_code_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = kmlr_pkg::slot(profile_reg, base_reg, key_reg);
        ram_wdata      = head.code;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop            = 1'b1;
                    walk_mask_next = head.mask;
                    work_mask_next = head.mask;
                    base_next      = head.base;
                    key_next       = head.key;
                    cur_next       = head.cur;
                    res_next       = '0;
                    pend_next      = 1'b0;
                    state_next     = S_OUT;
                    if (head.kind == kmlr_pkg::KIND_WRITE)
                    begin
                        ram_we   = 1'b1;
                        ram_addr = kmlr_pkg::slot(head.prof, head.layer, head.key);
                    end
                    else if (head.kind == kmlr_pkg::KIND_LOOKUP &&
                             32'(profile_reg) < 32'(kmlr_pkg::NUM_PROFILES))
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (pend_reg && ram_rdata != transp_reg)
                begin
                    res_next   = ram_rdata;
                    state_next = S_OUT;
                end
                else if (walk_mask_reg != '0)
                begin
                    ram_addr       = kmlr_pkg::slot(profile_reg, walk_top, key_reg);
                    walk_mask_next = walk_mask_reg & ~(kmlr_pkg::mask_t'(1) << walk_top);
                    pend_next      = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                res_next   = ram_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_layer_next = cur_reg;
                    out_code_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            profile_reg   <= '0;
            transp_reg    <= kmlr_pkg::code_t'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_we && cfg_index == kmlr_pkg::CFG_PROFILE)
            begin
                profile_reg <= cfg_data[kmlr_pkg::PROF_W-1:0];
            end
            if (cfg_we && cfg_index == kmlr_pkg::CFG_TRANSPARENT)
            begin
                transp_reg <= cfg_data[kmlr_pkg::CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_mask_reg <= walk_mask_next;
        work_mask_reg <= work_mask_next;
        base_reg      <= base_next;
        key_reg       <= key_next;
        cur_reg       <= cur_next;
        res_reg       <= res_next;
        out_layer_reg <= out_layer_next;
        out_code_reg  <= out_code_next;
    end

    // The store is only written while a queued item is being taken.
    `KLR_ASSERT(a_write_on_pop, clk, rst_n, ram_we |-> (pop && state_reg == S_IDLE))
    // The walk never visits a layer outside the snapshot taken with the item.
    `KLR_ASSERT(a_walk_subset, clk, rst_n, state_reg == S_WALK |-> (walk_mask_reg & ~work_mask_reg) == '0)
    // The default entry is read only after the walk ran out of layers.
    `KLR_ASSERT(a_base_after_walk, clk, rst_n, state_reg == S_BASE |-> $past(state_reg) == S_WALK && $past(walk_mask_reg) == '0)

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the keymap layer resolver block.
`timescale 1ns / 100ps

module tb;
    import kmlr_pkg::*;

    // Mode 7 has no operation behind it: the block must answer it with the
    // current layer and a zero keycode and change nothing.
    localparam mode_t MODE_UNUSED = 3'd7;

    // Register indexes that exist on the port but name no register.
    localparam cfg_idx_t CFG_SPARE_A = 2'd2;
    localparam cfg_idx_t CFG_SPARE_B = 2'd3;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 30;

    // One input transfer. The first declared member sits in the highest bits
    // of a packed struct, so mode lands in bit 0 as the port comment asks.
    typedef struct packed {
        code_t  code;
        prof_t  prof;
        key_t   key;
        layer_t layer;
        mode_t  mode;
    } key_event_t;

    // One result transfer: current layer and the keycode a lookup resolved.
    typedef struct packed {
        layer_t layer;
        code_t  code;
    } layer_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    cfg_idx_t              cfg_index = CFG_PROFILE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    keymap_layer_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state of the layer stack. It is advanced once per accepted
    // input transfer, in acceptance order, so it always matches what the
    // block has seen so far.
    // ------------------------------------------------------------------
    mask_t  mask_copy = '0;
    layer_t base_copy = '0;
    prof_t  profile_setting = '0;
    code_t  transparent_setting = 16'h0001;
    code_t  keymap_copy [NUM_PROFILES][NUM_LAYERS][NUM_KEYS];
    bit     entry_written [NUM_PROFILES][NUM_LAYERS][NUM_KEYS];

    // Results still owed by the block, oldest first.
    layer_result_t pending_results [$];

    // Idle behavior of both sides, switched by the tests.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_request = 1'b0;

    int error_count = 0;
    int events_sent = 0;
    int results_checked = 0;
    int lookups_sent = 0;
    int default_answers = 0;
    int settings_applied = 0;
    int quiet_cycles = 0;

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Highest active layer, or the default layer when no layer is active.
    function automatic layer_t top_active_layer();
        for (int i = NUM_LAYERS - 1; i >= 0; i--)
        begin
            if (mask_copy[i])
            begin
                return layer_t'(i);
            end
        end
        return base_copy;
    endfunction

    // Walks the active layers from the top down, in the order the block reads
    // its keymap, and stops at the first keycode that is not transparent.
    // When every active layer is transparent the default layer's entry is the
    // answer as stored. Returns 0 and names the layer when the walk would
    // touch an entry that was never written; the stimulus uses that to fill
    // the hole first instead of issuing the lookup.
    function automatic bit walk_layers(input key_t key, output code_t found,
                                       output layer_t missing, output bit from_base);
        found = '0;
        missing = '0;
        from_base = 1'b0;
        for (int i = int'(top_active_layer()); i >= 0; i--)
        begin
            if (mask_copy[i])
            begin
                if (!entry_written[profile_setting][i][key])
                begin
                    missing = layer_t'(i);
                    return 1'b0;
                end
                if (keymap_copy[profile_setting][i][key] != transparent_setting)
                begin
                    found = keymap_copy[profile_setting][i][key];
                    return 1'b1;
                end
            end
        end
        if (!entry_written[profile_setting][base_copy][key])
        begin
            missing = base_copy;
            return 1'b0;
        end
        found = keymap_copy[profile_setting][base_copy][key];
        from_base = 1'b1;
        return 1'b1;
    endfunction

    // Applies one accepted transfer to the shadow state and returns the result
    // the block owes for it. Every field is in range at these widths, so no
    // operation is ever dropped for a bad layer, key or profile.
    function automatic layer_result_t predict_layer_step(input key_event_t ev);
        layer_result_t r;
        layer_t        unused_layer;
        bit            from_base;
        r.code = '0;
        case (ev.mode)
            MODE_ON:      mask_copy[ev.layer] = 1'b1;
            MODE_OFF:     mask_copy[ev.layer] = 1'b0;
            MODE_TOGGLE:  mask_copy[ev.layer] = ~mask_copy[ev.layer];
            MODE_GOTO:    mask_copy = mask_t'(1) << ev.layer;
            MODE_DEFAULT: base_copy = ev.layer;
            MODE_WRITE:
            begin
                keymap_copy[ev.prof][ev.layer][ev.key] = ev.code;
                entry_written[ev.prof][ev.layer][ev.key] = 1'b1;
            end
            MODE_LOOKUP:
            begin
                void'(walk_layers(ev.key, r.code, unused_layer, from_base));
                lookups_sent++;
                if (from_base)
                begin
                    default_answers++;
                end
            end
            default: ;
        endcase
        r.layer = top_active_layer();
        return r;
    endfunction

    function automatic key_event_t make_event(input mode_t mode, input layer_t layer,
                                              input key_t key, input prof_t prof,
                                              input code_t code);
        key_event_t ev;
        ev.mode = mode;
        ev.layer = layer;
        ev.key = key;
        ev.prof = prof;
        ev.code = code;
        return ev;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(3, 1);
        end
        else if (r < 97)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(40, 15);
    endfunction

    // Keycodes lean toward the transparent code so that lookups fall through
    // layers often, with the all-zero and all-one codes mixed in.
    function automatic code_t pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return transparent_setting;
        end
        else if (r < 50)
        begin
            return 16'h0000;
        end
        else if (r < 60)
        begin
            return 16'hFFFF;
        end
        return code_t'($urandom_range(65535));
    endfunction

    // A handful of keys carry most of the traffic so that lookups find their
    // entries filled. Together they set and clear every key bit.
    function automatic key_t pool_key();
        case ($urandom_range(5))
            0: return 6'd0;
            1: return 6'd63;
            2: return 6'd21;
            3: return 6'd42;
            4: return 6'd5;
            default: return 6'd58;
        endcase
    endfunction

    // Builds one random transfer from the current shadow state. A lookup that
    // would read an entry never written turns into the write of that entry,
    // so the keymap slice of the active profile fills up as the run goes.
    function automatic key_event_t make_random_event();
        key_event_t ev;
        int         pick;
        code_t      unused_code;
        layer_t     missing;
        bit         from_base;
        ev.mode = mode_t'($urandom_range(7));
        ev.layer = layer_t'($urandom_range(15));
        ev.key = key_t'($urandom_range(63));
        ev.prof = prof_t'($urandom_range(3));
        ev.code = code_t'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            ev.mode = MODE_LOOKUP;
            ev.key = pool_key();
            if (!walk_layers(ev.key, unused_code, missing, from_base))
            begin
                ev.mode = MODE_WRITE;
                ev.layer = missing;
                ev.prof = profile_setting;
                ev.code = pick_code();
            end
        end
        else if (pick < 60)
        begin
            ev.mode = MODE_WRITE;
            if ($urandom_range(99) < 80)
            begin
                ev.key = pool_key();
            end
            if ($urandom_range(99) < 70)
            begin
                ev.prof = profile_setting;
            end
            ev.code = pick_code();
        end
        else if (pick < 70)
        begin
            ev.mode = MODE_ON;
        end
        else if (pick < 78)
        begin
            ev.mode = MODE_OFF;
        end
        else if (pick < 86)
        begin
            ev.mode = MODE_TOGGLE;
        end
        else if (pick < 92)
        begin
            ev.mode = MODE_GOTO;
        end
        else if (pick < 96)
        begin
            ev.mode = MODE_DEFAULT;
        end
        else
        begin
            ev.mode = MODE_UNUSED;
        end
        return ev;
    endfunction

    // Offers one transfer from a falling edge and holds it until the block
    // takes it. The expectation is queued at the accepting edge, then the
    // sender may idle. With no gap, valid simply stays high for the next item.
    task automatic send_event(input key_event_t ev);
        layer_result_t r;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, ev};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_layer_step(ev);
        pending_results.push_back(r);
        events_sent++;
        @(negedge clk);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random_events(input int count);
        repeat (count) send_event(make_random_event());
    endtask

    // The sender stops and waits until the block has delivered every result
    // it owes. Each transfer yields exactly one result, so once the queue is
    // empty the block holds no work and registers may be written.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROFILE:     profile_setting = value[PROF_W-1:0];
            CFG_TRANSPARENT: transparent_setting = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Applies one profile and transparent code. The profile register gets
    // random upper bits that the block must ignore, and the two unused
    // indexes get random writes that must change nothing.
    task automatic apply_setting(input prof_t prof, input code_t transparent);
        wait_for_results();
        write_register(CFG_PROFILE, {14'($urandom_range(16383)), prof});
        write_register(CFG_SPARE_A, 16'($urandom_range(65535)));
        write_register(CFG_TRANSPARENT, transparent);
        write_register(CFG_SPARE_B, 16'($urandom_range(65535)));
        settings_applied++;
    endtask

    // Every operation at least once at reset settings, with the fall-through cases
    // spelled out: a transparent top layer falling back to the default entry,
    // an empty stack answering the default entry even when it is transparent,
    // and the unused mode answering a zero keycode.
    task automatic test_directed_operations();
        send_event(make_event(MODE_UNUSED, 4'd9, 6'd17, 2'd2, 16'h5A5A));
        send_event(make_event(MODE_WRITE, 4'd0, 6'd0, 2'd0, 16'h1234));
        send_event(make_event(MODE_WRITE, 4'd15, 6'd0, 2'd0, 16'h0001));
        send_event(make_event(MODE_WRITE, 4'd7, 6'd0, 2'd0, 16'hFFFF));
        send_event(make_event(MODE_LOOKUP, 4'd15, 6'd0, 2'd3, 16'hFFFF));
        send_event(make_event(MODE_ON, 4'd15, 6'd63, 2'd3, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_ON, 4'd7, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd7, 6'd0, 2'd1, 16'hAAAA));
        send_event(make_event(MODE_UNUSED, 4'd0, 6'd0, 2'd0, 16'hFFFF));
        send_event(make_event(MODE_TOGGLE, 4'd15, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_OFF, 4'd7, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_OFF, 4'd3, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_DEFAULT, 4'd15, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_WRITE, 4'd15, 6'd63, 2'd0, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd0, 6'd63, 2'd0, 16'h0000));
        send_event(make_event(MODE_GOTO, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_TOGGLE, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_WRITE, 4'd15, 6'd63, 2'd3, 16'hFFFF));
        send_event(make_event(MODE_GOTO, 4'd15, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_ON, 4'd0, 6'd0, 2'd0, 16'h0000));
        send_event(make_event(MODE_LOOKUP, 4'd0, 6'd63, 2'd0, 16'h0000));
        send_event(make_event(MODE_DEFAULT, 4'd0, 6'd0, 2'd0, 16'h0000));
    endtask

    // Random traffic under several register settings, the extremes of both
    // registers among them. A new profile's keymap slice may start with holes,
    // which the lookup-to-write substitution fills.
    task automatic test_register_settings();
        apply_setting(2'd3, 16'h0000);
        send_random_events(100);
        apply_setting(2'd1, 16'hFFFF);
        send_random_events(100);
        apply_setting(2'd2, code_t'($urandom_range(65535)));
        send_random_events(100);
        apply_setting(2'd0, 16'h0001);
        send_random_events(100);
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // back to back, so the work queue fills and the input must stall.
    task automatic test_output_backpressure();
        wait_for_results();
        tx_idle_on = 1'b0;
        rx_hold_request = 1'b1;
        send_random_events(40);
        tx_idle_on = 1'b1;
        wait_for_results();
    endtask

    // Segments with every combination of idling on the two sides. Between
    // segments the sender drains the block and a fresh setting is applied.
    task automatic test_mixed_traffic();
        for (int seg = 0; seg < 5; seg++)
        begin
            tx_idle_on = (seg != 1) && (seg != 3);
            rx_idle_on = (seg != 1) && (seg != 2);
            send_random_events(90);
            apply_setting(prof_t'($urandom_range(3)), pick_code());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: ready changes only at falling edges. A hold request from a
    // test turns into a counted stall of fixed length.
    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_idle_on)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        layer_result_t want;
        layer_t        got_layer;
        code_t         got_code;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_layer = m_axis_tdata[3:0];
            got_code = m_axis_tdata[19:4];
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual 0x%06h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got_layer !== want.layer)
                begin
                    error_count++;
                    $display("%0t: current_layer mismatch, expected %0d, actual %0d",
                             $time, want.layer, got_layer);
                end
                if (got_code !== want.code)
                begin
                    error_count++;
                    $display("%0t: resolved_code mismatch, expected 0x%04h, actual 0x%04h",
                             $time, want.code, got_code);
                end
                if (m_axis_tdata[23:20] !== 4'h0)
                begin
                    error_count++;
                    $display("%0t: tdata padding mismatch, expected 0x0, actual 0x%0h",
                             $time, m_axis_tdata[23:20]);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // The keymap copy starts unwritten; the stimulus never reads a hole.
        for (int p = 0; p < NUM_PROFILES; p++)
        begin
            for (int l = 0; l < NUM_LAYERS; l++)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    keymap_copy[p][l][k] = '0;
                    entry_written[p][l][k] = 1'b0;
                end
            end
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_operations();
        test_register_settings();
        test_output_backpressure();
        test_mixed_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d transfers and checked %0d results, %0d of them lookups",
                 events_sent, results_checked, lookups_sent);
        $display("%0d lookups answered from the default layer, %0d register settings used",
                 default_answers, settings_applied);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
